@@ rtl/vgdf_pkg.sv @@
// Package for the vertical feathering filter: widths, codes, sequencer
// states and the inversion helper. No dependencies.
`default_nettype none
package vgdf_pkg;

  localparam int PixW     = 16;
  localparam int CoefW    = 16;
  localparam int RowW     = 12;
  localparam int HeightW  = 13;
  localparam int RadW     = 5;
  localparam int StepW    = 5;
  localparam int TabDepth = 64;
  localparam int TabAw    = $clog2(TabDepth);
  localparam int RingAw   = 6;
  localparam int ValW     = PixW + 1;
  localparam int AccW     = 39;
  localparam int WsumW    = 22;
  localparam int QW       = 17;
  localparam int DivCntW  = 5;
  localparam int ProdW    = 2 * ValW;
  localparam int MaxHeight = 4096;
  localparam int MaxStep   = 16;

  localparam logic [ValW-1:0] PixOne = ValW'(1) << PixW;

  typedef enum logic [1:0] {
    ACT_PIXEL = 2'd0,
    ACT_GAUSS = 2'd1,
    ACT_DIST  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CFG_INVERT = 2'd0,
    CFG_RADIUS = 2'd1,
    CFG_STEP   = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_OWN, ST_TAP, ST_DIVI, ST_DIV, ST_BLEND, ST_EMIT
  } state_t;

  // Value to one minus value when enabled, else passed through; an input at or above one maps to zero.
  function automatic logic [ValW-1:0] inv_val(input logic [ValW-1:0] v, input logic en);
    if (!en) return v;
    return (v >= PixOne) ? '0 : PixOne - v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/vgdf_ram.sv @@
// Generic single write, single read RAM with a registered read port.
// No dependencies.
`default_nettype none
module vgdf_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/vertical_gauss_dilate_feather_core.sv @@
// Top level of the vertical feathering filter: sequencer, tap datapath,
// radix-2 divider and blend. Uses vgdf_pkg and vgdf_ram.
//
// A pixel word emits zero or more rows (up to radius+1 at the end of a
// column); coefficient words emit nothing. Each row has a setup step, then
// reads one sampled tap per cycle, set by the single read port of the window
// ring, then a pipeline drain, the one-bit-per-cycle divider (skipped when
// the weight sum is zero) and the blend. A pixel word is held off until its
// last row has been loaded into the output register.
`default_nettype none
module vertical_gauss_dilate_feather_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_action,
  input  wire logic [vgdf_pkg::PixW-1:0]     in_pixel_in,
  input  wire logic [vgdf_pkg::TabAw-1:0]    in_tap_index,
  input  wire logic [vgdf_pkg::CoefW-1:0]    in_coef_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [vgdf_pkg::PixW-1:0]     out_pixel_out,
  output logic      [vgdf_pkg::RowW-1:0]     out_out_row,
  output logic                               out_last_of_column,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [vgdf_pkg::HeightW-1:0]  cfg_data
);
  import vgdf_pkg::*;

  state_t state_r, state_nxt;

  logic               invert_r;
  logic [RadW-1:0]    radius_r;
  logic [StepW-1:0]   step_r;
  logic [HeightW-1:0] height_r;

  logic [RowW-1:0]    row_cnt_r;
  logic [RowW-1:0]    y_r, last_r;
  logic [HeightW-1:0] ymax_r, t_r;
  logic               own_pend_r, pend_r, gv_r, dv_r;
  logic [ValW-1:0]    vmax_r, dmax_r;
  logic [AccW-1:0]    acc_r;
  logic [WsumW-1:0]   wsum_r;
  logic [WsumW-1:0]   rem_r;
  logic [QW-1:0]      num_lo_r, q_r;
  logic [DivCntW-1:0] cnt_r;
  logic [ProdW-1:0]   p1_r, p2_r;
  logic [TabDepth-1:0] gvalid_r, dvalid_r;

  logic out_valid_r;
  logic [PixW-1:0] out_pix_r;
  logic [RowW-1:0] out_row_r;
  logic            out_last_r;

  // Accept decode
  logic in_acc, pix_acc, g_wr, d_wr;
  assign in_acc  = in_valid && !in_stall;
  assign pix_acc = in_acc && (in_action == ACT_PIXEL);
  assign g_wr    = in_acc && (in_action == ACT_GAUSS);
  assign d_wr    = in_acc && (in_action == ACT_DIST);

  // Row selection for an accepted pixel
  logic [HeightW-1:0] r_ext, r_p1;
  logic               ends, emits;
  logic [RowW-1:0]    first_row;
  assign r_ext = {1'b0, row_cnt_r};
  assign r_p1  = r_ext + HeightW'(1);
  assign ends  = (r_p1 >= height_r);
  assign emits = ends || (row_cnt_r >= RowW'(radius_r));
  assign first_row = (row_cnt_r > RowW'(radius_r)) ? row_cnt_r - RowW'(radius_r) : '0;

  // Window bounds of row y_r
  logic [RowW-1:0]    ymin;
  logic [HeightW-1:0] yr_sum;
  assign ymin   = (y_r > RowW'(radius_r)) ? y_r - RowW'(radius_r) : '0;
  assign yr_sum = {1'b0, y_r} + HeightW'(radius_r) + HeightW'(1);

  // Tap issue
  logic               issue;
  logic [HeightW-1:0] tab_idx;
  assign issue   = (state_r == ST_TAP) && (t_r < ymax_r);
  assign tab_idx = t_r - {1'b0, y_r} + HeightW'(radius_r);

  // Memory control
  logic              ring_we, ring_re, tab_re;
  logic [RingAw-1:0] ring_raddr;
  logic [PixW-1:0]   ring_rd;
  logic [CoefW-1:0]  g_rd, d_rd;

  always_comb begin
    ring_we    = pix_acc;
    ring_re    = 1'b0;
    tab_re     = 1'b0;
    ring_raddr = y_r[RingAw-1:0];
    unique case (state_r)
      ST_OWN: ring_re = 1'b1;
      ST_TAP: begin
        ring_re    = issue;
        tab_re     = issue;
        ring_raddr = t_r[RingAw-1:0];
      end
      default: ;
    endcase
  end

  vgdf_ram #(.Width(PixW), .Depth(1 << RingAw)) u_ring (
    .clk, .we(ring_we), .waddr(row_cnt_r[RingAw-1:0]), .wdata(in_pixel_in),
    .re(ring_re), .raddr(ring_raddr), .rdata(ring_rd)
  );
  vgdf_ram #(.Width(CoefW), .Depth(TabDepth)) u_gauss (
    .clk, .we(g_wr), .waddr(in_tap_index), .wdata(in_coef_in),
    .re(tab_re), .raddr(tab_idx[TabAw-1:0]), .rdata(g_rd)
  );
  vgdf_ram #(.Width(CoefW), .Depth(TabDepth)) u_dist (
    .clk, .we(d_wr), .waddr(in_tap_index), .wdata(in_coef_in),
    .re(tab_re), .raddr(tab_idx[TabAw-1:0]), .rdata(d_rd)
  );

  // Tap arithmetic on the data returned from the previous issue
  logic [ValW-1:0]   v, g, d, s;
  logic [ProdW-1:0]  vg, vd;
  assign v  = inv_val({1'b0, ring_rd}, invert_r);
  assign g  = gv_r ? {1'b0, g_rd} : '0;
  assign d  = dv_r ? {1'b0, d_rd} : '0;
  assign vg = v * g;
  assign vd = v * d;
  assign s  = vd[PixW +: ValW];

  // Divider step
  logic [WsumW:0]   rem2;
  logic             qbit;
  logic [AccW-1:0]  num;
  assign rem2 = {rem_r, num_lo_r[QW-1]};
  assign qbit = (rem2 >= {1'b0, wsum_r});
  assign num  = acc_r + AccW'(wsum_r >> 1);

  // Blend finish
  logic [ProdW:0]    bsum;
  logic [ValW+1:0]   fin;
  logic [ValW-1:0]   fin_inv;
  logic [PixW-1:0]   fin_sat;
  logic              out_load, more_rows;
  assign bsum     = {1'b0, p1_r} + {1'b0, p2_r} + (ProdW+1)'(32768);
  assign fin      = bsum[PixW +: ValW+2];
  assign fin_inv  = invert_r ? ((fin >= (ValW+2)'(PixOne)) ? '0 : PixOne - fin[ValW-1:0])
                             : ((fin > (ValW+2)'(PixOne)) ? PixOne : fin[ValW-1:0]);
  assign fin_sat  = (fin_inv >= PixOne) ? {PixW{1'b1}} : fin_inv[PixW-1:0];
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign more_rows = (y_r != last_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (pix_acc && emits) state_nxt = ST_OWN;
      ST_OWN:   state_nxt = ST_TAP;
      ST_TAP:   if (!issue && !pend_r && !own_pend_r) state_nxt = ST_DIVI;
      ST_DIVI:  state_nxt = (wsum_r == '0) ? ST_BLEND : ST_DIV;
      ST_DIV:   if (cnt_r == DivCntW'(QW - 1)) state_nxt = ST_BLEND;
      ST_BLEND: state_nxt = ST_EMIT;
      ST_EMIT:  if (out_load) state_nxt = more_rows ? ST_OWN : ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      invert_r    <= 1'b0;
      radius_r    <= '0;
      step_r      <= StepW'(1);
      height_r    <= HeightW'(1);
      row_cnt_r   <= '0;
      gvalid_r    <= '0;
      dvalid_r    <= '0;
      out_valid_r <= 1'b0;
      own_pend_r  <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_INVERT: invert_r <= cfg_data[0];
          CFG_RADIUS: radius_r <= cfg_data[RadW-1:0];
          CFG_STEP: begin
            if (cfg_data[StepW-1:0] == '0) step_r <= StepW'(1);
            else if (cfg_data[StepW-1:0] > StepW'(MaxStep)) step_r <= StepW'(MaxStep);
            else step_r <= cfg_data[StepW-1:0];
          end
          CFG_HEIGHT: begin
            if (cfg_data == '0) height_r <= HeightW'(1);
            else if (cfg_data > HeightW'(MaxHeight)) height_r <= HeightW'(MaxHeight);
            else height_r <= cfg_data;
          end
          default: ;
        endcase
      end
      if (g_wr) gvalid_r[in_tap_index] <= 1'b1;
      if (d_wr) dvalid_r[in_tap_index] <= 1'b1;
      if (pix_acc) row_cnt_r <= ends ? '0 : r_p1[RowW-1:0];
      own_pend_r <= (state_r == ST_OWN);
      pend_r     <= issue;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (pix_acc) begin
      y_r    <= ends ? first_row : row_cnt_r - RowW'(radius_r);
      last_r <= ends ? row_cnt_r : row_cnt_r - RowW'(radius_r);
    end
    if (issue) begin
      gv_r <= gvalid_r[tab_idx[TabAw-1:0]];
      dv_r <= dvalid_r[tab_idx[TabAw-1:0]];
      t_r  <= t_r + HeightW'(step_r);
    end
    unique case (state_r)
      ST_OWN: begin
        acc_r  <= '0;
        wsum_r <= '0;
        dmax_r <= PixOne;
        t_r    <= {1'b0, ymin};
        ymax_r <= (yr_sum < height_r) ? yr_sum : height_r;
      end
      ST_TAP: begin
        if (own_pend_r) vmax_r <= v;
        if (pend_r) begin
          acc_r  <= acc_r + AccW'(vg);
          wsum_r <= wsum_r + WsumW'(g);
          if (s > vmax_r) begin
            vmax_r <= s;
            dmax_r <= d;
          end
        end
      end
      ST_DIVI: begin
        rem_r    <= num[AccW-1:QW];
        num_lo_r <= num[QW-1:0];
        q_r      <= '0;
        cnt_r    <= '0;
      end
      ST_DIV: begin
        rem_r    <= qbit ? WsumW'(rem2 - {1'b0, wsum_r}) : rem2[WsumW-1:0];
        num_lo_r <= {num_lo_r[QW-2:0], 1'b0};
        q_r      <= {q_r[QW-2:0], qbit};
        cnt_r    <= cnt_r + DivCntW'(1);
      end
      ST_BLEND: begin
        p1_r <= vmax_r * dmax_r;
        p2_r <= q_r * (PixOne - dmax_r);
      end
      ST_EMIT: if (out_load) y_r <= y_r + RowW'(1);
      default: ;
    endcase
    if (out_load) begin
      out_pix_r  <= fin_sat;
      out_row_r  <= y_r;
      out_last_r <= ({1'b0, y_r} + HeightW'(1) == height_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pixel_out      = out_pix_r;
  assign out_out_row        = out_row_r;
  assign out_last_of_column = out_last_r;
endmodule
`default_nettype wire

@@ rtl/vgdf_checker.sv @@
// Port-level checks for the feathering filter, bound to its top level.
// Uses vgdf_pkg for the action codes.
`default_nettype none
module vgdf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  in_action,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_pixel_out
);
  import vgdf_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_out))
    else $error("stalled result word changed");

  // A new result word only appears while a pixel is being worked on.
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word without work in progress");

  // Coefficient and ignored words never start the sequencer.
  a_coef_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action != ACT_PIXEL |=> !in_stall)
    else $error("coefficient word made the block busy");
endmodule

bind vertical_gauss_dilate_feather_core vgdf_checker u_vgdf_checker (
  .clk, .rst_n, .in_valid, .in_stall, .in_action, .out_valid, .out_stall,
  .out_pixel_out
);
`default_nettype wire

@@ tb/vertical_gauss_dilate_feather_core_tb.sv @@
// Self-checking testbench for vertical_gauss_dilate_feather_core: a short directed table,
// one full column and random phases, checked against given rows or a feathering predictor.
// Depends on vgdf_pkg and the core RTL.
`timescale 1ns / 1ps
module vertical_gauss_dilate_feather_core_tb;
  import vgdf_pkg::*;

  typedef struct {
    logic [15:0] pix;
    logic [11:0] row;
    logic        last;
  } feather_row_t;

  typedef struct {
    action_t     act;
    logic [15:0] pix;
    logic [5:0]  tap;
    logic [15:0] coef;
    bit          typed;
    feather_row_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = ACT_PIXEL;
  logic [15:0] in_pixel_in = '0;
  logic [5:0] in_tap_index = '0;
  logic [15:0] in_coef_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_pixel_out;
  logic [11:0] out_out_row;
  logic out_last_of_column;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_INVERT;
  logic [12:0] cfg_data = '0;

  vertical_gauss_dilate_feather_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_pixel_in(in_pixel_in), .in_tap_index(in_tap_index), .in_coef_in(in_coef_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_pixel_out(out_pixel_out),
    .out_out_row(out_out_row), .out_last_of_column(out_last_of_column),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block's settings and storage.
  logic        sh_invert = 1'b0;
  logic [4:0]  sh_radius = '0;
  logic [4:0]  sh_step = 5'd1;
  logic [12:0] sh_height = 13'd1;
  logic [15:0] gauss_coef [64];
  logic [15:0] dist_coef [64];
  logic [15:0] column_ring [64];
  int unsigned rows_in = 0;

  feather_row_t rows_due[$];
  int unsigned  mismatches = 0;
  int unsigned  rows_seen = 0;
  bit           sender_burst = 1'b0;
  bit           receiver_burst = 1'b0;

  function automatic logic [16:0] flip(input logic [16:0] v);
    if (!sh_invert) return v;
    return (v >= 17'h10000) ? 17'd0 : 17'h10000 - v;
  endfunction

  function automatic logic [15:0] feather(input int unsigned y, input int unsigned rad,
                                          input int unsigned hgt, input int unsigned stp);
    logic [39:0] acc;
    logic [39:0] wsum;
    logic [39:0] avg;
    logic [16:0] vmax;
    logic [16:0] v;
    logic [16:0] dmax;
    logic [16:0] d;
    logic [33:0] s;
    logic [63:0] fin;
    int unsigned lo;
    int unsigned hi;
    int unsigned idx;
    acc = '0;
    wsum = '0;
    avg = '0;
    dmax = 17'h10000;
    lo = (y > rad) ? y - rad : 0;
    hi = (y + rad + 1 < hgt) ? y + rad + 1 : hgt;
    vmax = flip({1'b0, column_ring[y % 64]});
    for (int unsigned t = lo; t < hi; t += stp) begin
      idx = t + rad - y;
      v = flip({1'b0, column_ring[t % 64]});
      acc += v * gauss_coef[idx];
      wsum += gauss_coef[idx];
      if (v > vmax) begin
        d = {1'b0, dist_coef[idx]};
        s = (v * d) >> 16;
        if (s > vmax) begin
          vmax = s[16:0];
          dmax = d;
        end
      end
    end
    if (wsum != 0) avg = (acc + wsum / 2) / wsum;
    fin = (64'(vmax) * dmax + 64'(avg) * (64'h10000 - dmax) + 64'd32768) >> 16;
    fin = 64'(flip(fin[16:0]));
    return (fin > 64'hFFFF) ? 16'hFFFF : fin[15:0];
  endfunction

  // Applies one accepted word to the shadow state and queues the rows it releases.
  task automatic predict_word(input logic [1:0] act, input logic [15:0] pix,
                              input logic [5:0] tap, input logic [15:0] coef,
                              input bit typed, input feather_row_t want);
    int unsigned rad;
    int unsigned hgt;
    int unsigned stp;
    int unsigned r;
    int unsigned first;
    int unsigned lastrow;
    bit ends;
    feather_row_t fr;
    if (act == ACT_GAUSS) gauss_coef[tap] = coef;
    else if (act == ACT_DIST) dist_coef[tap] = coef;
    else if (act == ACT_PIXEL) begin
      rad = sh_radius;
      hgt = (sh_height == 0) ? 1 : ((sh_height > MaxHeight) ? MaxHeight : sh_height);
      stp = (sh_step == 0) ? 1 : ((sh_step > MaxStep) ? MaxStep : sh_step);
      r = rows_in;
      column_ring[r % 64] = pix;
      ends = (r + 1 >= hgt);
      if (!ends && r < rad) begin
        rows_in = r + 1;
      end else begin
        first = (r > rad) ? r - rad : 0;
        lastrow = ends ? r : first;
        for (int unsigned y = first; y <= lastrow; y++) begin
          fr.pix = feather(y, rad, hgt, stp);
          fr.row = y[11:0];
          fr.last = (y + 1 == hgt);
          rows_due.push_back(typed ? want : fr);
        end
        rows_in = ends ? 0 : r + 1;
      end
    end
  endtask

  task automatic send_word(input logic [1:0] act, input logic [15:0] pix,
                           input logic [5:0] tap, input logic [15:0] coef,
                           input bit typed, input feather_row_t want);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_pixel_in <= pix;
    in_tap_index <= tap;
    in_coef_in <= coef;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predict_word(act, pix, tap, coef, typed, want);
    if ($urandom_range(0, 19) == 0) sender_burst = !sender_burst;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [12:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_INVERT: sh_invert = data[0];
      CFG_RADIUS: sh_radius = data[4:0];
      CFG_STEP:   sh_step = data[4:0];
      default:    sh_height = data;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits for the block to drain; a pixel that releases no row may still be in flight.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_word;
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver: random stalls, one long hold-off while the sender keeps offering words.
  initial begin : receiver
    int unsigned gap;
    bit long_done;
    long_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!long_done && rows_seen >= 20) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        long_done = 1'b1;
      end
      gap = receiver_burst ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      if ($urandom_range(0, 19) == 0) receiver_burst = !receiver_burst;
    end
  end

  always @(posedge clk) begin
    feather_row_t exp_row;
    if (rst_n && out_valid && !out_stall) begin
      rows_seen++;
      if (rows_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: pix %h row %0d last %b",
                   out_pixel_out, out_out_row, out_last_of_column);
      end else begin
        exp_row = rows_due.pop_front();
        if (exp_row.pix !== out_pixel_out || exp_row.row !== out_out_row ||
            exp_row.last !== out_last_of_column) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp pix %h row %0d last %b, got pix %h row %0d last %b",
                     exp_row.pix, exp_row.row, exp_row.last,
                     out_pixel_out, out_out_row, out_last_of_column);
        end
      end
    end
  end

  initial begin : watchdog
    #50ms;
    $display("** vertical_gauss_dilate_feather_core: FAILED **");
    $finish;
  end

  initial begin : stimulus
    stim_row_t    plan[$];
    feather_row_t none;
    int unsigned  sent;
    int unsigned  len;
    int unsigned  pick;
    for (int i = 0; i < 64; i++) begin
      gauss_coef[i] = '0;
      dist_coef[i] = '0;
      column_ring[i] = '0;
    end
    none = '{pix: '0, row: '0, last: 1'b0};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // After reset the column is one row high with empty tables: each pixel comes back as is.
    plan.push_back('{ACT_PIXEL, 16'hFFFF, 6'd0, 16'd0, 1, '{16'hFFFF, 12'd0, 1'b1}});
    plan.push_back('{ACT_PIXEL, 16'h0000, 6'd0, 16'd0, 1, '{16'h0000, 12'd0, 1'b1}});
    plan.push_back('{ACT_NONE, 16'hFFFF, 6'd63, 16'hFFFF, 1, none});
    plan.push_back('{ACT_PIXEL, 16'h8001, 6'd0, 16'd0, 1, '{16'h8001, 12'd0, 1'b1}});
    plan.push_back('{ACT_GAUSS, 16'h0, 6'd0, 16'hFFFF, 0, none});
    plan.push_back('{ACT_DIST, 16'h0, 6'd0, 16'hFFFF, 0, none});
    plan.push_back('{ACT_PIXEL, 16'h1234, 6'd0, 16'd0, 0, none});
    plan.push_back('{ACT_DIST, 16'h0, 6'd0, 16'h8000, 0, none});
    plan.push_back('{ACT_PIXEL, 16'hFFFF, 6'd0, 16'd0, 0, none});
    plan.push_back('{ACT_GAUSS, 16'h0, 6'd63, 16'h0000, 0, none});
    plan.push_back('{ACT_DIST, 16'h0, 6'd63, 16'hFFFF, 0, none});
    plan.push_back('{ACT_GAUSS, 16'h0, 6'd42, 16'h5A5A, 0, none});
    plan.push_back('{ACT_DIST, 16'h0, 6'd21, 16'hA5A5, 0, none});
    plan.push_back('{ACT_PIXEL, 16'h0001, 6'd0, 16'd0, 0, none});
    plan.push_back('{ACT_GAUSS, 16'h0, 6'd0, 16'h0000, 0, none});
    plan.push_back('{ACT_PIXEL, 16'h7FFF, 6'd0, 16'd0, 0, none});
    foreach (plan[i])
      send_word(plan[i].act, plan[i].pix, plan[i].tap, plan[i].coef,
                plan[i].typed, plan[i].want);
    drain();

    // One full 64-row column writes every ring entry before settings move mid column.
    write_reg(CFG_RADIUS, 13'd2);
    write_reg(CFG_HEIGHT, 13'd64);
    write_reg(CFG_STEP, 13'd1);
    for (int i = 0; i < 5; i++) send_word(ACT_GAUSS, 0, 6'(i), rand_word(), 0, none);
    for (int i = 0; i < 5; i++) send_word(ACT_DIST, 0, 6'(i), rand_word(), 0, none);
    for (int i = 0; i < 64; i++) send_word(ACT_PIXEL, rand_word(), 0, 0, 0, none);
    drain();

    sent = 0;
    while (sent < 110) begin
      write_reg(CFG_INVERT, 13'($urandom_range(0, 1)));
      pick = $urandom_range(0, 9);
      write_reg(CFG_RADIUS, (pick == 0) ? 13'd31 : (pick == 1) ? 13'd0 :
                            13'($urandom_range(0, 31) & ((pick < 5) ? 31 : 7)));
      pick = $urandom_range(0, 9);
      write_reg(CFG_STEP, (pick == 0) ? 13'd0 : (pick == 1) ? 13'd16 :
                          (pick == 2) ? 13'd31 : 13'($urandom_range(1, 4)));
      pick = $urandom_range(0, 11);
      write_reg(CFG_HEIGHT, (pick == 0) ? 13'd0 : (pick == 1) ? 13'd8191 :
                            (pick == 2) ? 13'd4096 : (pick == 3) ? 13'd1 :
                            13'($urandom_range(2, 40)));
      len = $urandom_range(12, 30);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) send_word(ACT_GAUSS, rand_word(), 6'($urandom), rand_word(), 0, none);
        else if (pick < 12) send_word(ACT_DIST, rand_word(), 6'($urandom), rand_word(), 0, none);
        else if (pick < 15) begin
          send_word(ACT_NONE, rand_word(), 6'($urandom), rand_word(), 0, none);
          continue;
        end else send_word(ACT_PIXEL, rand_word(), 6'($urandom), rand_word(), 0, none);
        sent++;
      end
      drain();
    end

    if (mismatches == 0 && rows_due.size() == 0) begin
      $display("** vertical_gauss_dilate_feather_core: PASSED **");
    end else begin
      $display("** vertical_gauss_dilate_feather_core: FAILED **");
    end
    $finish;
  end

endmodule
